>>> src/bir_pkg.sv
`default_nettype none
package bir_pkg;

  localparam int unsigned DEF_MAX_SOURCE_HEIGHT = 256;
  localparam int unsigned DEF_MAX_SOURCE_WIDTH  = 256;
  localparam int unsigned CHANNELS   = 3;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned SRC_REG_W  = 9;
  localparam int unsigned TGT_REG_W  = 11;
  localparam int unsigned SCALE_W    = SRC_REG_W + FRAC_BITS;
  localparam int unsigned PROD_W     = SCALE_W + IDX_W;
  localparam int unsigned PIX_W      = 8 * CHANNELS;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned DEST_LIMIT = 4096;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = TGT_REG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_TGT_H = 3'd1,
    REG_TGT_W = 3'd2,
    REG_SRC_H = 3'd3,
    REG_SRC_W = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_HS,
    CS_WS,
    CS_RH,
    CS_RW
  } cfg_state_t;

  typedef struct packed {
    logic               busy;
    logic [SCALE_W-1:0] row_scale;
    logic [SCALE_W-1:0] col_scale;
    logic [DIM_W-1:0]   dest_h;
    logic [DIM_W-1:0]   dest_w;
    logic [DIM_W-1:0]   src_h;
    logic [DIM_W-1:0]   src_w;
  } derived_t;

  typedef struct packed {
    logic [IDX_W-1:0]     lo;
    logic [IDX_W-1:0]     hi;
    logic [FRAC_BITS-1:0] frac;
  } loc_t;

  typedef struct packed {
    logic                 is_read;
    logic                 oor;
    logic [IDX_W-1:0]     rlo;
    logic [IDX_W-1:0]     rhi;
    logic [IDX_W-1:0]     clo;
    logic [IDX_W-1:0]     chi;
    logic [FRAC_BITS-1:0] rfrac;
    logic [FRAC_BITS-1:0] cfrac;
    logic [PIX_W-1:0]     pixel;
  } q_item_t;

  typedef struct packed {
    logic [CHANNELS-1:0][VAL_W-1:0] value;
    logic                           status;
  } res_t;

endpackage
`default_nettype wire

>>> src/bir_fifo.sv
`default_nettype none
module bir_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              full,
  output logic              empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  data_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = data_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

>>> src/bir_cfg.sv
`default_nettype none
module bir_cfg import bir_pkg::*; #(
  parameter int unsigned MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
  parameter int unsigned MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output derived_t                   drv
);

  localparam int unsigned CNT_W = $clog2(SCALE_W + 1);

  cfg_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   mode_r;
  logic [TGT_REG_W-1:0]   tgt_h_r, tgt_w_r;
  logic [SRC_REG_W-1:0]   src_h_r, src_w_r;
  logic [SCALE_W-1:0]     num_r, hs_r, row_scale_r, col_scale_r;
  logic [SCALE_W:0]       rem_r;
  logic [DIM_W-1:0]       dest_h_r, dest_w_r;
  logic [DIM_W-1:0]       sh, sw;
  logic [TGT_REG_W-1:0]   th, tw;
  logic [SCALE_W-1:0]     dividend, divisor, quo_step, min_scale;
  logic [SCALE_W:0]       rem_sh, rem_step;
  logic                   ge, done, wr_ok;

  function automatic logic [DIM_W-1:0] relax(input logic [DIM_W-1:0] src,
                                             input logic [SCALE_W-1:0] scale,
                                             input logic [SCALE_W-1:0] q);
    logic [DIM_W-1:0] r;
    if (src <= DIM_W'(1)) begin
      r = DIM_W'(1);
    end else if (scale == '0 || q >= SCALE_W'(DEST_LIMIT)) begin
      r = DIM_W'(DEST_LIMIT);
    end else begin
      r = DIM_W'(q) + DIM_W'(1);
    end
    return r;
  endfunction

  assign sh = (src_h_r == '0) ? DIM_W'(1) :
              (DIM_W'(src_h_r) > DIM_W'(MAX_SOURCE_HEIGHT)) ? DIM_W'(MAX_SOURCE_HEIGHT) :
              DIM_W'(src_h_r);
  assign sw = (src_w_r == '0) ? DIM_W'(1) :
              (DIM_W'(src_w_r) > DIM_W'(MAX_SOURCE_WIDTH)) ? DIM_W'(MAX_SOURCE_WIDTH) :
              DIM_W'(src_w_r);
  assign th = (tgt_h_r < TGT_REG_W'(2)) ? TGT_REG_W'(2) : tgt_h_r;
  assign tw = (tgt_w_r < TGT_REG_W'(2)) ? TGT_REG_W'(2) : tgt_w_r;

  assign wr_ok = cfg_we && (cfg_index <= CFG_IDX_W'(REG_SRC_W));

  always_comb begin
    dividend = SCALE_W'(sh - DIM_W'(1)) << FRAC_BITS;
    divisor  = row_scale_r;
    case (state_r)
      CS_HS: divisor = SCALE_W'(th - TGT_REG_W'(1));
      CS_WS: begin
        dividend = SCALE_W'(sw - DIM_W'(1)) << FRAC_BITS;
        divisor  = SCALE_W'(tw - TGT_REG_W'(1));
      end
      CS_RW: dividend = SCALE_W'(sw - DIM_W'(1)) << FRAC_BITS;
      default: ;
    endcase
  end

  // one quotient bit per cycle, restoring
  assign rem_sh   = {rem_r[SCALE_W-1:0], num_r[SCALE_W-1]};
  assign ge       = (rem_sh >= {1'b0, divisor});
  assign rem_step = ge ? rem_sh - {1'b0, divisor} : rem_sh;
  assign quo_step = {num_r[SCALE_W-2:0], ge};
  assign done     = (cnt_r == CNT_W'(SCALE_W));
  assign min_scale = (hs_r < quo_step) ? hs_r : quo_step;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = (state_r == CS_IDLE) ? '0 : cnt_r + CNT_W'(1);
    unique case (state_r)
      CS_IDLE: ;
      CS_HS: if (done) begin
        state_nxt = CS_WS;
        cnt_nxt   = '0;
      end
      CS_WS: if (done) begin
        state_nxt = mode_r ? CS_RH : CS_IDLE;
        cnt_nxt   = '0;
      end
      CS_RH: if (done) begin
        state_nxt = CS_RW;
        cnt_nxt   = '0;
      end
      CS_RW: if (done) begin
        state_nxt = CS_IDLE;
        cnt_nxt   = '0;
      end
      default: begin
        state_nxt = CS_IDLE;
        cnt_nxt   = '0;
      end
    endcase
    if (wr_ok) begin
      state_nxt = CS_HS;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_HS;
      cnt_r   <= '0;
      mode_r  <= 1'b0;
      tgt_h_r <= TGT_REG_W'(256);
      tgt_w_r <= TGT_REG_W'(256);
      src_h_r <= SRC_REG_W'(256);
      src_w_r <= SRC_REG_W'(256);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MODE:  mode_r  <= cfg_wdata[0];
          REG_TGT_H: tgt_h_r <= cfg_wdata[TGT_REG_W-1:0];
          REG_TGT_W: tgt_w_r <= cfg_wdata[TGT_REG_W-1:0];
          REG_SRC_H: src_h_r <= cfg_wdata[SRC_REG_W-1:0];
          REG_SRC_W: src_w_r <= cfg_wdata[SRC_REG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_r == '0) begin
      num_r <= dividend;
      rem_r <= '0;
    end else begin
      num_r <= quo_step;
      rem_r <= rem_step;
    end
    if (done) begin
      case (state_r)
        CS_HS: hs_r <= quo_step;
        CS_WS: begin
          if (!mode_r) begin
            row_scale_r <= hs_r;
            col_scale_r <= quo_step;
            dest_h_r    <= DIM_W'(th);
            dest_w_r    <= DIM_W'(tw);
          end else begin
            row_scale_r <= min_scale;
            col_scale_r <= min_scale;
          end
        end
        CS_RH: dest_h_r <= relax(sh, row_scale_r, quo_step);
        CS_RW: dest_w_r <= relax(sw, row_scale_r, quo_step);
        default: ;
      endcase
    end
  end

  assign drv.busy      = (state_r != CS_IDLE);
  assign drv.row_scale = row_scale_r;
  assign drv.col_scale = col_scale_r;
  assign drv.dest_h    = dest_h_r;
  assign drv.dest_w    = dest_w_r;
  assign drv.src_h     = sh;
  assign drv.src_w     = sw;

endmodule
`default_nettype wire

>>> src/bir_front.sv
`default_nettype none
module bir_front import bir_pkg::*; #(
  parameter int unsigned MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
  parameter int unsigned MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_action,
  input  wire logic [IDX_W-1:0] in_row,
  input  wire logic [IDX_W-1:0] in_col,
  input  wire logic [7:0]       in_pixel_blue,
  input  wire logic [7:0]       in_pixel_green,
  input  wire logic [7:0]       in_pixel_red,
  input  wire derived_t         drv,
  input  wire logic             q_full,
  output logic                  q_push,
  output q_item_t               q_item
);

  logic              f_v_r, f_act_r, f_oor_r;
  logic [IDX_W-1:0]  f_row_r, f_col_r;
  logic [PIX_W-1:0]  f_pix_r;
  logic [PROD_W-1:0] f_prow_r, f_pcol_r;
  logic              in_acc, f_need, f_go;
  loc_t              rloc, cloc;

  function automatic loc_t locate(input logic [PROD_W-1:0] p,
                                  input logic [DIM_W-1:0] src);
    logic [PROD_W-FRAC_BITS-1:0] l;
    logic [IDX_W-1:0]            last;
    loc_t                        r;
    last = IDX_W'(src - DIM_W'(1));
    l    = p[PROD_W-1:FRAC_BITS];
    if (l >= (PROD_W-FRAC_BITS)'(last)) begin
      r.lo   = last;
      r.frac = '0;
    end else begin
      r.lo   = l[IDX_W-1:0];
      r.frac = p[FRAC_BITS-1:0];
    end
    r.hi = (r.lo < last) ? r.lo + IDX_W'(1) : last;
    return r;
  endfunction

  // writes outside the store are dropped here
  assign f_need = f_act_r ||
                  (({1'b0, f_row_r} < DIM_W'(MAX_SOURCE_HEIGHT)) &&
                   ({1'b0, f_col_r} < DIM_W'(MAX_SOURCE_WIDTH)));
  assign f_go     = f_v_r && (!f_need || !q_full);
  assign in_stall = drv.busy || (f_v_r && !f_go);
  assign in_acc   = in_valid && !in_stall;
  assign q_push   = f_v_r && f_need && !q_full;

  assign rloc = locate(f_prow_r, drv.src_h);
  assign cloc = locate(f_pcol_r, drv.src_w);

  always_comb begin
    q_item.is_read = f_act_r;
    q_item.oor     = f_oor_r;
    q_item.pixel   = f_pix_r;
    if (f_act_r) begin
      q_item.rlo   = rloc.lo;
      q_item.rhi   = rloc.hi;
      q_item.clo   = cloc.lo;
      q_item.chi   = cloc.hi;
      q_item.rfrac = rloc.frac;
      q_item.cfrac = cloc.frac;
    end else begin
      q_item.rlo   = f_row_r;
      q_item.rhi   = f_row_r;
      q_item.clo   = f_col_r;
      q_item.chi   = f_col_r;
      q_item.rfrac = '0;
      q_item.cfrac = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= in_acc || (f_v_r && !f_go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      f_act_r  <= in_action;
      f_row_r  <= in_row;
      f_col_r  <= in_col;
      f_pix_r  <= {in_pixel_red, in_pixel_green, in_pixel_blue};
      f_oor_r  <= ({1'b0, in_row} >= drv.dest_h) || ({1'b0, in_col} >= drv.dest_w);
      f_prow_r <= PROD_W'(drv.row_scale) * PROD_W'(in_row);
      f_pcol_r <= PROD_W'(drv.col_scale) * PROD_W'(in_col);
    end
  end

endmodule
`default_nettype wire

>>> src/bir_back.sv
`default_nettype none
module bir_back import bir_pkg::*; #(
  parameter int unsigned MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
  parameter int unsigned MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_valid,
  input  wire q_item_t q_item,
  output logic         q_pop,
  output logic         res_push,
  output res_t         res_data,
  input  wire logic    res_pop
);

  localparam int unsigned MEM_DEPTH = MAX_SOURCE_HEIGHT * MAX_SOURCE_WIDTH;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
  localparam int unsigned RC_W      = $clog2(OUT_DEPTH + 1);
  localparam int unsigned W_W       = FRAC_BITS + 1;
  localparam int unsigned H_W       = 8 + W_W;
  localparam int unsigned ACC_W     = H_W + W_W;
  localparam int unsigned SHIFT     = 2 * FRAC_BITS - 8;

  logic [PIX_W-1:0]     mem [MEM_DEPTH];
  logic [PIX_W-1:0]     rdata_r;
  logic [1:0]           ph_r, rd_ph_r;
  logic                 rd_v_r;
  logic [RC_W-1:0]      res_cnt_r;
  logic [FRAC_BITS-1:0] wt_rf_r, wt_cf_r;
  logic [PIX_W-1:0]     px0_r, px1_r, px2_r;

  logic                 s0_v_r, s0_oor_r;
  logic [3:0][PIX_W-1:0] s0_pix_r;
  logic [FRAC_BITS-1:0] s0_rf_r, s0_cf_r;

  logic                 s1_v_r, s1_oor_r;
  logic [CHANNELS-1:0][H_W-1:0] s1_top_r, s1_bot_r;
  logic [W_W-1:0]       s1_wrl_r;
  logic [FRAC_BITS-1:0] s1_wrh_r;

  logic                 mem_we, mem_re, take, flag_push, last_arr, can_res;
  logic [IDX_W-1:0]     r_idx, c_idx;
  logic [MEM_AW-1:0]    addr;
  logic [W_W-1:0]       wcl;

  assign last_arr = rd_v_r && (rd_ph_r == 2'd3);
  assign can_res  = (res_cnt_r < RC_W'(OUT_DEPTH));

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    q_pop     = 1'b0;
    take      = 1'b0;
    flag_push = 1'b0;
    r_idx     = q_item.rlo;
    c_idx     = q_item.clo;
    case (ph_r)
      2'd1: c_idx = q_item.chi;
      2'd2: r_idx = q_item.rhi;
      2'd3: begin
        r_idx = q_item.rhi;
        c_idx = q_item.chi;
      end
      default: ;
    endcase
    if (q_valid) begin
      if (!q_item.is_read) begin
        mem_we = 1'b1;
        q_pop  = 1'b1;
      end else if (q_item.oor) begin
        // hold back while a gathered read enters the blend stage now, or while the output queue has no room to reserve
        if (can_res && !last_arr) begin
          flag_push = 1'b1;
          q_pop     = 1'b1;
          take      = 1'b1;
        end
      end else if (ph_r != 2'd0 || can_res) begin
        mem_re = 1'b1;
        take   = (ph_r == 2'd0);
        q_pop  = (ph_r == 2'd3);
      end
    end
  end

  assign addr = MEM_AW'(32'(r_idx) * MAX_SOURCE_WIDTH + 32'(c_idx));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= q_item.pixel;
    end
    if (mem_re) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= '0;
      rd_v_r    <= 1'b0;
      res_cnt_r <= '0;
      s0_v_r    <= 1'b0;
      s1_v_r    <= 1'b0;
    end else begin
      if (mem_re) begin
        ph_r <= ph_r + 2'd1;
      end
      rd_v_r    <= mem_re;
      res_cnt_r <= res_cnt_r + RC_W'(take) - RC_W'(res_pop);
      s0_v_r    <= last_arr || flag_push;
      s1_v_r    <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_ph_r <= ph_r;
    if (mem_re && ph_r == 2'd3) begin
      wt_rf_r <= q_item.rfrac;
      wt_cf_r <= q_item.cfrac;
    end
    if (rd_v_r) begin
      case (rd_ph_r)
        2'd0: px0_r <= rdata_r;
        2'd1: px1_r <= rdata_r;
        2'd2: px2_r <= rdata_r;
        default: ;
      endcase
    end
    if (last_arr) begin
      s0_pix_r <= {rdata_r, px2_r, px1_r, px0_r};
      s0_rf_r  <= wt_rf_r;
      s0_cf_r  <= wt_cf_r;
      s0_oor_r <= 1'b0;
    end else if (flag_push) begin
      s0_pix_r <= '0;
      s0_rf_r  <= '0;
      s0_cf_r  <= '0;
      s0_oor_r <= 1'b1;
    end
  end

  // horizontal blend of the top and bottom neighbour pairs
  assign wcl = W_W'(1 << FRAC_BITS) - W_W'(s0_cf_r);

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      s1_top_r[ch] <= H_W'(s0_pix_r[0][8*ch +: 8]) * H_W'(wcl)
                    + H_W'(s0_pix_r[1][8*ch +: 8]) * H_W'(s0_cf_r);
      s1_bot_r[ch] <= H_W'(s0_pix_r[2][8*ch +: 8]) * H_W'(wcl)
                    + H_W'(s0_pix_r[3][8*ch +: 8]) * H_W'(s0_cf_r);
    end
    s1_wrl_r <= W_W'(1 << FRAC_BITS) - W_W'(s0_rf_r);
    s1_wrh_r <= s0_rf_r;
    s1_oor_r <= s0_oor_r;
  end

  // vertical blend, result lands in the output queue
  always_comb begin
    logic [ACC_W-1:0] acc;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      acc = ACC_W'(s1_wrl_r) * ACC_W'(s1_top_r[ch])
          + ACC_W'(s1_wrh_r) * ACC_W'(s1_bot_r[ch]);
      res_data.value[ch] = acc[SHIFT +: VAL_W];
    end
    res_data.status = s1_oor_r;
  end

  assign res_push = s1_v_r;

endmodule
`default_nettype wire

>>> src/bilinear_image_resize_unit.sv
`default_nettype none
// Bilinear resize with aligned corners. Write beats (action 0) load one
// source pixel into an internal store of MAX_SOURCE_HEIGHT x MAX_SOURCE_WIDTH
// entries; read beats (action 1) return one 8.8 pixel per channel, each
// from four neighbour fetches through the single port of that store. Reads
// outside the destination come back flagged with zero values. After reset
// and after every register write the unit stalls its input while a shared
// 1-bit-per-cycle divider derives the scales, and in relaxed mode also the
// destination size. Results wait in a small output queue, so input keeps
// flowing while out_stall is high until that queue is full.
module bilinear_image_resize_unit import bir_pkg::*; #(
  parameter int unsigned MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
  parameter int unsigned MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_action,
  input  wire logic [IDX_W-1:0]      in_row,
  input  wire logic [IDX_W-1:0]      in_col,
  input  wire logic [7:0]            in_pixel_blue,
  input  wire logic [7:0]            in_pixel_green,
  input  wire logic [7:0]            in_pixel_red,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [VAL_W-1:0]           out_value_blue,
  output logic [VAL_W-1:0]           out_value_green,
  output logic [VAL_W-1:0]           out_value_red,
  output logic [DIM_W-1:0]           out_height,
  output logic [DIM_W-1:0]           out_width,
  output logic                       out_status
);

  derived_t drv;
  q_item_t  fq_item, bq_item;
  res_t     res_in, res_out;
  logic     q_push, q_pop, q_full, q_empty;
  logic     res_push, res_pop, out_full, out_empty;

  bir_cfg #(
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .drv       (drv)
  );

  bir_front #(
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_pixel_blue  (in_pixel_blue),
    .in_pixel_green (in_pixel_green),
    .in_pixel_red   (in_pixel_red),
    .drv            (drv),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (fq_item)
  );

  bir_fifo #(
    .W     ($bits(q_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (fq_item),
    .pop   (q_pop),
    .dout  (bq_item),
    .full  (q_full),
    .empty (q_empty)
  );

  bir_back #(
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (!q_empty),
    .q_item   (bq_item),
    .q_pop    (q_pop),
    .res_push (res_push),
    .res_data (res_in),
    .res_pop  (res_pop)
  );

  bir_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .pop   (res_pop),
    .dout  (res_out),
    .full  (out_full),
    .empty (out_empty)
  );

  // the back end reserves room before starting a result, so this never overflows
  assign out_valid       = !out_empty && !(out_full && 1'b0);
  assign res_pop         = out_valid && !out_stall;
  assign out_value_blue  = res_out.value[0];
  assign out_value_green = res_out.value[1];
  assign out_value_red   = res_out.value[2];
  assign out_status      = res_out.status;
  assign out_height      = drv.dest_h;
  assign out_width       = drv.dest_w;

endmodule
`default_nettype wire

>>> src/bir_checker.sv
`default_nettype none
module bir_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_value_blue,
  input wire logic [15:0] out_value_green,
  input wire logic [15:0] out_value_red,
  input wire logic [12:0] out_height,
  input wire logic [12:0] out_width,
  input wire logic        out_status
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |->
      out_value_blue == 16'd0 && out_value_green == 16'd0 && out_value_red == 16'd0)
    else $error("flagged beat carries nonzero value");

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_height != 13'd0 && out_height <= 13'd4096 &&
                  out_width != 13'd0 && out_width <= 13'd4096)
    else $error("destination size out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_blue) &&
      $stable(out_value_green) && $stable(out_value_red) && $stable(out_status))
    else $error("stalled beat changed");

endmodule

bind bilinear_image_resize_unit bir_checker u_bir_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_value_blue  (out_value_blue),
  .out_value_green (out_value_green),
  .out_value_red   (out_value_red),
  .out_height      (out_height),
  .out_width       (out_width),
  .out_status      (out_status)
);
`default_nettype wire
